@@ src/spcs_pkg.sv @@
// shared types, widths and codes for the scan position compare sequencer
// no dependencies; imported by every module of the block
package spcs_pkg;

   localparam int POSITION_BITS = 32;
   localparam int POS_W         = 32;
   localparam int DIST_W        = 31;
   localparam int COUNT_W       = 24;
   localparam int SCALE_W       = 16;
   localparam int DIR_W         = 2;
   localparam int CSR_DATA_W    = 31;
   localparam int CSR_INDEX_W   = 3;
   localparam int OVL_W         = 3;

   localparam logic [OVL_W-1:0] OVERLAP_LIMIT = OVL_W'(3);

   localparam int SPAN_W    = DIST_W + 2;
   localparam int NUM_W     = DIST_W + COUNT_W + 3;
   localparam int MAG_W     = NUM_W - 1;
   localparam int DEN_W     = COUNT_W + SCALE_W;
   localparam int WHOLE_W   = NUM_W + 1;
   localparam int MUL_CNT_W = $clog2(COUNT_W);
   localparam int DIV_CNT_W = $clog2(MAG_W);

   localparam logic [WHOLE_W-1:0] LIMIT_HI =
      WHOLE_W'((65'd1 << (POSITION_BITS - 1)) - 65'd1);
   localparam logic [WHOLE_W-1:0] LIMIT_LO = ~LIMIT_HI;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_HIT   = 2'd1,
      CMD_ECHO  = 2'd2,
      CMD_ARM   = 2'd3
   } command_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_RUNUP     = 3'd0,
      REG_TRAVEL    = 3'd1,
      REG_STOP      = 3'd2,
      REG_COUNT     = 3'd3,
      REG_SCALE     = 3'd4,
      REG_DIRECTION = 3'd5,
      REG_ECHO_WAIT = 3'd6
   } csr_index_type;

   typedef struct packed {
      command_type              command;
      logic signed [POS_W-1:0]  encoder_position;
   } req_payload_type;

   typedef struct packed {
      logic                     pulse;
      logic                     report_valid;
      logic [COUNT_W-1:0]       report_count;
      logic signed [POS_W-1:0]  report_position;
      logic                     compare_enable;
      logic signed [POS_W-1:0]  compare_value;
      logic                     scan_error;
      logic                     finished;
   } rsp_payload_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  n;
      logic [COUNT_W-1:0]  m;
      logic [SCALE_W-1:0]  sc;
      logic [DIST_W-1:0]   runup;
      logic [SPAN_W-1:0]   span;
      logic [POS_W-1:0]    start_pos;
      logic                neg;
   } point_req_type;

endpackage

@@ src/spcs_mul.sv @@
// bit-serial shift-add unit: num = runup*m + n*span and den = m*sc
// one multiplier bit per cycle, msb first; uses spcs_pkg
module spcs_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  spcs_pkg::point_req_type       point_req,
   output logic                          done,
   output logic [spcs_pkg::NUM_W-1:0]    num,
   output logic [spcs_pkg::DEN_W-1:0]    den
);
   import spcs_pkg::*;

   logic [COUNT_W-1:0]   m_sh_ff, m_sh_in;
   logic [COUNT_W-1:0]   n_sh_ff, n_sh_in;
   logic [SCALE_W-1:0]   sc_ff;
   logic [DIST_W-1:0]    runup_ff;
   logic [SPAN_W-1:0]    span_ff;
   logic [NUM_W-1:0]     num_ff, num_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [NUM_W-1:0]     runup_ext;
   logic [NUM_W-1:0]     span_ext;

   assign runup_ext = {{(NUM_W-DIST_W){1'b0}}, runup_ff};
   assign span_ext  = {{(NUM_W-SPAN_W){span_ff[SPAN_W-1]}}, span_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      m_sh_in = m_sh_ff;
      n_sh_in = n_sh_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = MUL_CNT_W'(COUNT_W - 1);
         m_sh_in = point_req.m;
         n_sh_in = point_req.n;
         num_in  = '0;
         den_in  = '0;
      end else if (busy_ff) begin
         num_in  = {num_ff[NUM_W-2:0], 1'b0}
                 + (m_sh_ff[COUNT_W-1] ? runup_ext : '0)
                 + (n_sh_ff[COUNT_W-1] ? span_ext : '0);
         den_in  = {den_ff[DEN_W-2:0], 1'b0}
                 + (m_sh_ff[COUNT_W-1] ? {{(DEN_W-SCALE_W){1'b0}}, sc_ff} : '0);
         m_sh_in = {m_sh_ff[COUNT_W-2:0], 1'b0};
         n_sh_in = {n_sh_ff[COUNT_W-2:0], 1'b0};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      m_sh_ff <= m_sh_in;
      n_sh_ff <= n_sh_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      if (start) begin
         sc_ff    <= point_req.sc;
         runup_ff <= point_req.runup;
         span_ff  <= point_req.span;
      end
   end

   assign done = done_ff;
   assign num  = num_ff;
   assign den  = den_ff;

endmodule

@@ src/spcs_div.sv @@
// restoring divider, one quotient bit per cycle
// unsigned magnitude over the point denominator; uses spcs_pkg
module spcs_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [spcs_pkg::MAG_W-1:0]    dividend,
   input  logic [spcs_pkg::DEN_W-1:0]    divisor,
   output logic                          done,
   output logic [spcs_pkg::MAG_W-1:0]    quotient,
   output logic                          rem_nonzero
);
   import spcs_pkg::*;

   logic [MAG_W-1:0]     q_sh_ff, q_sh_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     den_ff;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DEN_W:0]       trial;
   logic [DEN_W:0]       diff;
   logic                 fits;

   assign trial = {rem_ff, q_sh_ff[MAG_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_sh_in = q_sh_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(MAG_W - 1);
         q_sh_in = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         q_sh_in = {q_sh_ff[MAG_W-2:0], fits};
         rem_in  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_sh_ff <= q_sh_in;
      rem_ff  <= rem_in;
      if (start) begin
         den_ff <= divisor;
      end
   end

   assign done        = done_ff;
   assign quotient    = q_sh_ff;
   assign rem_nonzero = |rem_ff;

endmodule

@@ src/spcs_point.sv @@
// compare point unit: serial multiply, serial divide, then signed sum,
// truncation toward zero and saturation; uses spcs_pkg, spcs_mul, spcs_div
module spcs_point (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  spcs_pkg::point_req_type       point_req,
   output logic                          done,
   output logic [spcs_pkg::POS_W-1:0]    value
);
   import spcs_pkg::*;

   typedef enum logic [5:0] {
      P_IDLE = 6'b000001,
      P_MUL  = 6'b000010,
      P_DIV  = 6'b000100,
      P_SUM  = 6'b001000,
      P_ADJ  = 6'b010000,
      P_SAT  = 6'b100000
   } pstate_type;

   pstate_type         state_ff, state_in;
   logic               done_ff, done_in;
   logic [POS_W-1:0]   value_ff, value_in;
   logic [POS_W-1:0]   start_pos_ff;
   logic               neg_ff;
   logic               num_neg_ff;
   logic [WHOLE_W-1:0] whole_ff, whole_in;

   logic               mul_done;
   logic [NUM_W-1:0]   mul_num;
   logic [DEN_W-1:0]   mul_den;
   logic [NUM_W-1:0]   num_abs;
   logic               div_done;
   logic [MAG_W-1:0]   div_q;
   logic               div_rnz;

   logic [WHOLE_W-1:0] start_ext;
   logic [WHOLE_W-1:0] q_ext;
   logic               frac_up;
   logic               frac_down;
   logic               whole_neg;
   logic               whole_pos;
   logic [WHOLE_W-POSITION_BITS:0] upper;
   logic               in_range;
   logic [WHOLE_W-1:0] sat;

   spcs_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .point_req (point_req),
      .done      (mul_done),
      .num       (mul_num),
      .den       (mul_den)
   );

   assign num_abs = mul_num[NUM_W-1] ? (~mul_num + 1'b1) : mul_num;

   spcs_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (mul_done),
      .dividend    (num_abs[MAG_W-1:0]),
      .divisor     (mul_den),
      .done        (div_done),
      .quotient    (div_q),
      .rem_nonzero (div_rnz)
   );

   assign start_ext = {{(WHOLE_W-POS_W){start_pos_ff[POS_W-1]}}, start_pos_ff};
   assign q_ext     = {{(WHOLE_W-MAG_W){1'b0}}, div_q};
   assign frac_up   = div_rnz & (num_neg_ff == neg_ff);
   assign frac_down = div_rnz & (num_neg_ff != neg_ff);
   assign whole_neg = whole_ff[WHOLE_W-1];
   assign whole_pos = ~whole_ff[WHOLE_W-1] & (|whole_ff);
   assign upper     = whole_ff[WHOLE_W-1:POSITION_BITS-1];
   assign in_range  = (&upper) | ~(|upper);
   assign sat       = in_range ? whole_ff : (whole_neg ? LIMIT_LO : LIMIT_HI);

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      value_in = value_ff;
      whole_in = whole_ff;
      case (state_ff)
         P_IDLE: begin
            if (start) begin
               state_in = P_MUL;
            end
         end
         P_MUL: begin
            if (mul_done) begin
               state_in = P_DIV;
            end
         end
         P_DIV: begin
            if (div_done) begin
               state_in = P_SUM;
            end
         end
         P_SUM: begin
            whole_in = (num_neg_ff ^ neg_ff) ? (start_ext - q_ext) : (start_ext + q_ext);
            state_in = P_ADJ;
         end
         P_ADJ: begin
            if (frac_up && whole_neg) begin
               whole_in = whole_ff + 1'b1;
            end else if (frac_down && whole_pos) begin
               whole_in = whole_ff - 1'b1;
            end
            state_in = P_SAT;
         end
         P_SAT: begin
            value_in = sat[POS_W-1:0];
            done_in  = 1'b1;
            state_in = P_IDLE;
         end
         default: begin
            state_in = P_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      whole_ff <= whole_in;
      if (start) begin
         start_pos_ff <= point_req.start_pos;
         neg_ff       <= point_req.neg;
      end
      if (mul_done) begin
         num_neg_ff <= mul_num[NUM_W-1];
      end
   end

   assign done  = done_ff;
   assign value = value_ff;

endmodule

@@ src/scan_position_compare_sequencer.sv @@
// top level of the scan position compare sequencer: command decode, scan state,
// configuration registers and result register; uses spcs_pkg and spcs_point
//
//   channel   ports                                      direction
//   req       req_valid, req_ready, req_data             item in
//   rsp       rsp_valid, rsp_ready, rsp_data             result out
//   csr       csr_write_enable, csr_index, csr_write_data  register write
//
// an item that loads a new compare point goes through the serial multiply, the serial
// divide, sum, rounding and clamp, then handoff and the result register before the next
// possible transfer; other items go straight to the result register
// one item is in work at a time
// the result register lets the next item be taken while a result waits
// synchronous reset clears all scan state, loads the register defaults, holds req_ready low
module scan_position_compare_sequencer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  spcs_pkg::req_payload_type            req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output spcs_pkg::rsp_payload_type            rsp_data,
   input  logic                                 csr_write_enable,
   input  logic [spcs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [spcs_pkg::CSR_DATA_W-1:0]      csr_write_data
);
   import spcs_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CALC = 3'b010,
      ST_OUT  = 3'b100
   } state_type;

   // configuration
   logic [DIST_W-1:0]  runup_ff;
   logic [DIST_W-1:0]  travel_ff;
   logic [DIST_W-1:0]  stop_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic [DIR_W-1:0]   dir_ff;
   logic               echo_wait_ff;

   // scan state
   state_type          state_ff, state_in;
   logic               running_ff, running_in;
   logic               awaiting_ff, awaiting_in;
   logic               armed_ff, armed_in;
   logic               cmp_armed_ff, cmp_armed_in;
   logic [COUNT_W-1:0] issued_ff, issued_in;
   logic [COUNT_W-1:0] echoes_ff, echoes_in;
   logic [OVL_W-1:0]   ovl_ff, ovl_in;
   logic [POS_W-1:0]   start_pos_ff, start_pos_in;
   logic [POS_W-1:0]   next_cmp_ff;

   // pending result fields
   logic               pend_pulse_ff, pend_pulse_in;
   logic               pend_rep_ff, pend_rep_in;
   logic [COUNT_W-1:0] pend_cnt_ff, pend_cnt_in;
   logic [POS_W-1:0]   pend_pos_ff, pend_pos_in;
   logic               pend_err_ff, pend_err_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff;

   logic               accept;
   logic               load_rsp;
   logic               calc_go;
   logic [COUNT_W-1:0] calc_n;
   logic               do_hit;
   logic               abort;
   logic [COUNT_W-1:0] eff_count;
   logic [COUNT_W-1:0] mult_m;
   logic [SCALE_W-1:0] eff_scale;
   logic [SPAN_W-1:0]  span;
   point_req_type      point_req;
   logic               point_done;
   logic [POS_W-1:0]   point_value;

   assign req_ready = (state_ff == ST_IDLE) & ~reset;
   assign accept    = req_valid & req_ready;
   assign load_rsp  = (state_ff == ST_OUT) & (~rsp_valid_ff | rsp_ready);

   assign eff_count = (count_ff == '0) ? COUNT_W'(1) : count_ff;
   assign mult_m    = (count_ff <= COUNT_W'(1)) ? COUNT_W'(1) : (count_ff - 1'b1);
   assign eff_scale = (scale_ff == '0) ? SCALE_W'(1) : scale_ff;
   assign span      = {2'b00, travel_ff} - {2'b00, stop_ff} - {2'b00, runup_ff};

   always_comb begin
      point_req.n         = calc_n;
      point_req.m         = mult_m;
      point_req.sc        = eff_scale;
      point_req.runup     = runup_ff;
      point_req.span      = span;
      point_req.start_pos = start_pos_in;
      point_req.neg       = dir_ff[DIR_W-1];
   end

   spcs_point u_point (
      .clock     (clock),
      .reset     (reset),
      .start     (calc_go),
      .point_req (point_req),
      .done      (point_done),
      .value     (point_value)
   );

   // command decode
   always_comb begin
      running_in    = running_ff;
      awaiting_in   = awaiting_ff;
      armed_in      = armed_ff;
      cmp_armed_in  = cmp_armed_ff;
      issued_in     = issued_ff;
      echoes_in     = echoes_ff;
      ovl_in        = ovl_ff;
      start_pos_in  = start_pos_ff;
      pend_pulse_in = pend_pulse_ff;
      pend_rep_in   = pend_rep_ff;
      pend_cnt_in   = pend_cnt_ff;
      pend_pos_in   = pend_pos_ff;
      pend_err_in   = pend_err_ff;
      calc_go       = 1'b0;
      calc_n        = '0;
      do_hit        = 1'b0;
      abort         = 1'b0;
      if (accept) begin
         pend_pulse_in = 1'b0;
         pend_rep_in   = 1'b0;
         pend_cnt_in   = '0;
         pend_pos_in   = '0;
         pend_err_in   = 1'b0;
         case (req_data.command)
            CMD_START: begin
               running_in   = 1'b1;
               awaiting_in  = 1'b0;
               armed_in     = 1'b0;
               cmp_armed_in = 1'b0;
               issued_in    = COUNT_W'(1);
               echoes_in    = '0;
               ovl_in       = '0;
               start_pos_in = req_data.encoder_position;
               if (runup_ff == '0) begin
                  do_hit = 1'b1;
               end else begin
                  calc_go      = 1'b1;
                  calc_n       = '0;
                  cmp_armed_in = 1'b1;
               end
            end
            CMD_HIT: begin
               do_hit = running_ff & cmp_armed_ff;
            end
            CMD_ECHO: begin
               if (running_ff && echo_wait_ff) begin
                  echoes_in   = echoes_ff + 1'b1;
                  awaiting_in = 1'b0;
                  if (armed_ff) begin
                     armed_in    = 1'b0;
                     pend_rep_in = 1'b1;
                     pend_cnt_in = echoes_in;
                     pend_pos_in = req_data.encoder_position;
                  end
                  if (echoes_in == eff_count) begin
                     running_in   = 1'b0;
                     cmp_armed_in = 1'b0;
                  end
               end
            end
            CMD_ARM: begin
               armed_in = 1'b1;
            end
            default: begin
               armed_in = armed_ff;
            end
         endcase

         if (do_hit) begin
            if (echo_wait_ff) begin
               if (awaiting_in) begin
                  if (ovl_in > OVERLAP_LIMIT) begin
                     pend_err_in  = 1'b1;
                     running_in   = 1'b0;
                     cmp_armed_in = 1'b0;
                     abort        = 1'b1;
                  end else begin
                     ovl_in      = ovl_in + 1'b1;
                     echoes_in   = echoes_in + 1'b1;
                     awaiting_in = 1'b0;
                     if (armed_in) begin
                        armed_in    = 1'b0;
                        pend_rep_in = 1'b1;
                        pend_cnt_in = echoes_in;
                        pend_pos_in = req_data.encoder_position;
                     end
                  end
               end
               if (!abort) begin
                  awaiting_in   = 1'b1;
                  pend_pulse_in = 1'b1;
               end
            end else begin
               pend_pulse_in = 1'b1;
               pend_rep_in   = 1'b1;
               pend_cnt_in   = issued_in;
               pend_pos_in   = '0;
            end
            if (!abort) begin
               if (issued_in < eff_count) begin
                  calc_go      = 1'b1;
                  calc_n       = issued_in;
                  issued_in    = issued_in + 1'b1;
                  cmp_armed_in = 1'b1;
               end else begin
                  cmp_armed_in = 1'b0;
               end
               if (echo_wait_ff) begin
                  if (echoes_in == eff_count) begin
                     running_in   = 1'b0;
                     cmp_armed_in = 1'b0;
                  end
               end else if (!cmp_armed_in) begin
                  running_in = 1'b0;
               end
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = calc_go ? ST_CALC : ST_OUT;
            end
         end
         ST_CALC: begin
            if (point_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         runup_ff     <= '0;
         travel_ff    <= '0;
         stop_ff      <= '0;
         count_ff     <= COUNT_W'(1);
         scale_ff     <= SCALE_W'(1);
         dir_ff       <= DIR_W'(1);
         echo_wait_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_RUNUP:     runup_ff     <= csr_write_data[DIST_W-1:0];
            REG_TRAVEL:    travel_ff    <= csr_write_data[DIST_W-1:0];
            REG_STOP:      stop_ff      <= csr_write_data[DIST_W-1:0];
            REG_COUNT:     count_ff     <= csr_write_data[COUNT_W-1:0];
            REG_SCALE:     scale_ff     <= csr_write_data[SCALE_W-1:0];
            REG_DIRECTION: dir_ff       <= csr_write_data[DIR_W-1:0];
            REG_ECHO_WAIT: echo_wait_ff <= csr_write_data[0];
            default:       echo_wait_ff <= echo_wait_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         running_ff   <= 1'b0;
         awaiting_ff  <= 1'b0;
         armed_ff     <= 1'b0;
         cmp_armed_ff <= 1'b0;
         issued_ff    <= '0;
         echoes_ff    <= '0;
         ovl_ff       <= '0;
         start_pos_ff <= '0;
         next_cmp_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         awaiting_ff  <= awaiting_in;
         armed_ff     <= armed_in;
         cmp_armed_ff <= cmp_armed_in;
         issued_ff    <= issued_in;
         echoes_ff    <= echoes_in;
         ovl_ff       <= ovl_in;
         start_pos_ff <= start_pos_in;
         rsp_valid_ff <= rsp_valid_in;
         if (point_done) begin
            next_cmp_ff <= point_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_pulse_ff <= pend_pulse_in;
      pend_rep_ff   <= pend_rep_in;
      pend_cnt_ff   <= pend_cnt_in;
      pend_pos_ff   <= pend_pos_in;
      pend_err_ff   <= pend_err_in;
      if (load_rsp) begin
         rsp_data_ff.pulse           <= pend_pulse_ff;
         rsp_data_ff.report_valid    <= pend_rep_ff;
         rsp_data_ff.report_count    <= pend_cnt_ff;
         rsp_data_ff.report_position <= pend_pos_ff;
         rsp_data_ff.compare_enable  <= cmp_armed_ff;
         rsp_data_ff.compare_value   <= next_cmp_ff;
         rsp_data_ff.scan_error      <= pend_err_ff;
         rsp_data_ff.finished        <= ~running_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for scan_position_compare_sequencer: directed table, then random
// scans under random idling on both channels; depends on spcs_pkg and the block's top module
module tb;
   import spcs_pkg::*;

   typedef struct packed {
      logic [DIST_W-1:0] runup;
      logic [DIST_W-1:0] travel;
      logic [DIST_W-1:0] stop;
      logic [DIST_W-1:0] count;
      logic [DIST_W-1:0] scale;
      logic [DIST_W-1:0] direction;
      logic [DIST_W-1:0] echo_wait;
   } settings_type;

   typedef struct packed {
      logic [2:0]      phase;
      command_type     command;
      logic [POS_W-1:0] position;
      logic            known;
      rsp_payload_type result;
   } directed_row_type;

   localparam rsp_payload_type IDLE_RESULT = '{pulse: 1'b0, report_valid: 1'b0,
      report_count: '0, report_position: '0, compare_enable: 1'b0, compare_value: '0,
      scan_error: 1'b0, finished: 1'b1};
   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_ITEMS  = 1500;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_payload_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_payload_type rsp_data;
   logic csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   scan_position_compare_sequencer dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // register copies
   logic [DIST_W-1:0]  cfg_runup;
   logic [DIST_W-1:0]  cfg_travel;
   logic [DIST_W-1:0]  cfg_stop;
   logic [COUNT_W-1:0] cfg_count;
   logic [SCALE_W-1:0] cfg_scale;
   logic [DIR_W-1:0]   cfg_dir;
   logic               cfg_echo;

   // scan state
   logic               st_running;
   logic               st_awaiting;
   logic               st_report_armed;
   logic               st_compare_armed;
   longint             st_start_pos;
   longint             st_next;
   logic [COUNT_W:0]   st_issued;
   logic [COUNT_W-1:0] st_echoes;
   logic [OVL_W-1:0]   st_overlaps;

   logic               o_pulse;
   logic               o_rep;
   logic               o_err;
   logic [COUNT_W-1:0] o_cnt;
   longint             o_pos;

   rsp_payload_type scan_outcomes[$];
   directed_row_type directed_rows [DIRECTED_ROWS];
   int mismatches;
   int overlap_bias;

   always #5 clock = ~clock;

   function automatic longint points_in_scan();
      return (cfg_count == 0) ? 64'sd1 : longint'(cfg_count);
   endfunction

   function automatic longint point_at(logic [COUNT_W:0] n);
      longint c, sc, num, den, q, r, whole, span, lim_hi, lim_lo;
      logic neg;
      int fs;
      c = points_in_scan();
      sc = (cfg_scale == 0) ? 64'sd1 : longint'(cfg_scale);
      neg = cfg_dir[1];
      if (c <= 1) begin
         num = longint'(cfg_runup);
         den = sc;
      end else begin
         span = longint'(cfg_travel) - longint'(cfg_stop) - longint'(cfg_runup);
         num = longint'(cfg_runup) * (c - 1) + longint'(n) * span;
         den = (c - 1) * sc;
      end
      q = num / den;
      r = num % den;
      whole = st_start_pos + (neg ? -q : q);
      fs = 0;
      if (r != 0) fs = ((r > 0) != neg) ? 1 : -1;
      // truncate the exact sum toward zero
      if (fs > 0 && whole < 0) whole += 1;
      else if (fs < 0 && whole > 0) whole -= 1;
      lim_hi = (longint'(1) << (POSITION_BITS - 1)) - 1;
      lim_lo = -lim_hi - 1;
      if (whole > lim_hi) whole = lim_hi;
      if (whole < lim_lo) whole = lim_lo;
      return whole;
   endfunction

   function automatic void end_scan();
      st_running = 1'b0;
      st_compare_armed = 1'b0;
   endfunction

   function automatic void take_echo(longint pos);
      st_echoes = st_echoes + 1'b1;
      st_awaiting = 1'b0;
      if (st_report_armed) begin
         st_report_armed = 1'b0;
         o_rep = 1'b1;
         o_cnt = st_echoes;
         o_pos = pos;
      end
   endfunction

   function automatic void check_done();
      if (cfg_echo) begin
         if (longint'(st_echoes) == points_in_scan()) end_scan();
      end else if (!st_compare_armed) begin
         end_scan();
      end
   endfunction

   function automatic void take_hit(longint pos);
      if (cfg_echo) begin
         if (st_awaiting) begin
            if (st_overlaps > OVERLAP_LIMIT) begin
               o_err = 1'b1;
               end_scan();
               return;
            end
            st_overlaps = st_overlaps + 1'b1;
            take_echo(pos);
         end
         st_awaiting = 1'b1;
         o_pulse = 1'b1;
      end else begin
         o_pulse = 1'b1;
         o_rep = 1'b1;
         o_cnt = st_issued[COUNT_W-1:0];
         o_pos = 0;
      end
      if (longint'(st_issued) < points_in_scan()) begin
         st_next = point_at(st_issued);
         st_issued = st_issued + 1'b1;
         st_compare_armed = 1'b1;
      end else begin
         st_compare_armed = 1'b0;
      end
      check_done();
   endfunction

   function automatic rsp_payload_type scan_step(req_payload_type item);
      rsp_payload_type r;
      longint pos;
      pos = longint'($signed(item.encoder_position));
      o_pulse = 1'b0;
      o_rep = 1'b0;
      o_err = 1'b0;
      o_cnt = '0;
      o_pos = 0;
      case (item.command)
         CMD_START: begin
            st_running = 1'b1;
            st_awaiting = 1'b0;
            st_report_armed = 1'b0;
            st_compare_armed = 1'b0;
            st_issued = '0;
            st_echoes = '0;
            st_overlaps = '0;
            st_start_pos = pos;
            if (cfg_runup == 0) begin
               st_issued = (COUNT_W+1)'(1);
               take_hit(pos);
            end else begin
               st_next = point_at('0);
               st_issued = (COUNT_W+1)'(1);
               st_compare_armed = 1'b1;
            end
         end
         CMD_HIT: begin
            if (st_running && st_compare_armed) take_hit(pos);
         end
         CMD_ECHO: begin
            if (st_running && cfg_echo) begin
               take_echo(pos);
               check_done();
            end
         end
         default: st_report_armed = 1'b1;
      endcase
      r.pulse = o_pulse;
      r.report_valid = o_rep;
      r.report_count = o_cnt;
      r.report_position = o_pos[POS_W-1:0];
      r.compare_enable = st_compare_armed;
      r.compare_value = st_next[POS_W-1:0];
      r.scan_error = o_err;
      r.finished = !st_running;
      return r;
   endfunction

   function automatic logic [DIST_W-1:0] pick_distance();
      case ($urandom_range(0, 5))
         0: return 31'd0;
         1: return 31'h7FFF_FFFF;
         2: return 31'($urandom_range(0, 5000));
         default: return 31'($urandom());
      endcase
   endfunction

   function automatic settings_type pick_settings();
      settings_type s;
      logic [DIST_W-1:0] junk;
      logic [COUNT_W-1:0] cnt;
      logic [SCALE_W-1:0] sc;
      junk = 31'($urandom());
      s.runup = ($urandom_range(0, 2) == 0) ? 31'd0 : pick_distance();
      s.travel = pick_distance();
      s.stop = pick_distance();
      case ($urandom_range(0, 7))
         0: cnt = '0;
         1: cnt = '1;
         2: cnt = 24'($urandom());
         default: cnt = 24'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 5))
         0: sc = '0;
         1: sc = '1;
         2: sc = 16'($urandom());
         default: sc = 16'($urandom_range(1, 4));
      endcase
      // upper bits beyond each register's width are junk
      s.count = {junk[DIST_W-1:COUNT_W], cnt};
      s.scale = {junk[DIST_W-1:SCALE_W], sc};
      s.direction = 31'($urandom());
      s.echo_wait = 31'($urandom());
      return s;
   endfunction

   function automatic req_payload_type pick_item();
      req_payload_type it;
      int roll;
      it.encoder_position = $urandom();
      roll = $urandom_range(0, 99);
      if (roll < 15) it.command = command_type'($urandom_range(0, 3));
      else if (!st_running) it.command = CMD_START;
      else if (roll < 20) it.command = CMD_ARM;
      else if (roll < 23) it.command = CMD_START;
      else if (cfg_echo && st_awaiting && $urandom_range(0, 99) >= overlap_bias)
         it.command = CMD_ECHO;
      else if (st_compare_armed) it.command = CMD_HIT;
      else if (cfg_echo) it.command = CMD_ECHO;
      else it.command = CMD_HIT;
      return it;
   endfunction

   function automatic settings_type directed_settings(logic [2:0] phase);
      settings_type s;
      case (phase)
         3'd1: s = '{31'd1000, 31'd3000, 31'd0, 31'd3, 31'd1, 31'd1, 31'd0};
         3'd2: s = '{31'h7FFF_FFFF, 31'd0, 31'h7FFF_FFFF, 31'hFF_FFFF, 31'd0, 31'd3, 31'd0};
         3'd3: s = '{31'd0, 31'h7FFF_FFFF, 31'd0, 31'd0, 31'hFFFF, 31'd2, 31'd1};
         default: s = '{31'd5, 31'd40000, 31'd1000, 31'd20, 31'd7, 31'd0, 31'd1};
      endcase
      return s;
   endfunction

   task automatic write_reg(csr_index_type idx, logic [DIST_W-1:0] word);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= word;
      @(posedge clock);
      case (idx)
         REG_RUNUP:     cfg_runup = word;
         REG_TRAVEL:    cfg_travel = word;
         REG_STOP:      cfg_stop = word;
         REG_COUNT:     cfg_count = word[COUNT_W-1:0];
         REG_SCALE:     cfg_scale = word[SCALE_W-1:0];
         REG_DIRECTION: cfg_dir = word[DIR_W-1:0];
         REG_ECHO_WAIT: cfg_echo = word[0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(settings_type s);
      write_reg(REG_RUNUP, s.runup);
      write_reg(REG_TRAVEL, s.travel);
      write_reg(REG_STOP, s.stop);
      write_reg(REG_COUNT, s.count);
      write_reg(REG_SCALE, s.scale);
      write_reg(REG_DIRECTION, s.direction);
      write_reg(REG_ECHO_WAIT, s.echo_wait);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // drop valid and wait for every pending outcome
   task automatic settle();
      req_valid <= 1'b0;
      while (scan_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_item(req_payload_type item, logic known, rsp_payload_type result);
      rsp_payload_type predicted;
      int gap;
      gap = $urandom_range(0, 5);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!(req_valid && req_ready));
      predicted = scan_step(item);
      scan_outcomes.push_back(known ? result : predicted);
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_outcome(rsp_payload_type got);
      rsp_payload_type want;
      if (scan_outcomes.size() == 0) begin
         $error("result transfer with no outcome pending");
         mismatches++;
      end else begin
         want = scan_outcomes.pop_front();
         check_field("pulse", 32'(want.pulse), 32'(got.pulse));
         check_field("report_valid", 32'(want.report_valid), 32'(got.report_valid));
         check_field("report_count", 32'(want.report_count), 32'(got.report_count));
         check_field("report_position", want.report_position, got.report_position);
         check_field("compare_enable", 32'(want.compare_enable), 32'(got.compare_enable));
         check_field("compare_value", want.compare_value, got.compare_value);
         check_field("scan_error", 32'(want.scan_error), 32'(got.scan_error));
         check_field("finished", 32'(want.finished), 32'(got.finished));
      end
   endtask

   initial begin
      int i;
      int items_sent;
      int phase_len;
      logic [2:0] cur_phase;
      req_payload_type item;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      mismatches = 0;
      overlap_bias = 15;
      cfg_runup = '0;
      cfg_travel = '0;
      cfg_stop = '0;
      cfg_count = 24'd1;
      cfg_scale = 16'd1;
      cfg_dir = 2'd1;
      cfg_echo = 1'b0;
      st_running = 1'b0;
      st_awaiting = 1'b0;
      st_report_armed = 1'b0;
      st_compare_armed = 1'b0;
      st_start_pos = 0;
      st_next = 0;
      st_issued = '0;
      st_echoes = '0;
      st_overlaps = '0;
      directed_rows = '{
         '{3'd0, CMD_HIT,   32'h0000_0000, 1'b1, IDLE_RESULT},
         '{3'd0, CMD_ECHO,  32'h7FFF_FFFF, 1'b1, IDLE_RESULT},
         '{3'd0, CMD_ARM,   32'h8000_0000, 1'b1, IDLE_RESULT},
         '{3'd0, CMD_START, 32'h0000_0064, 1'b0, '0},
         '{3'd0, CMD_HIT,   32'hFFFF_FFFF, 1'b0, '0},
         '{3'd1, CMD_ARM,   32'h0000_0000, 1'b0, '0},
         '{3'd1, CMD_START, 32'hFFFF_FFFB, 1'b0, '0},
         '{3'd1, CMD_HIT,   32'h0000_03E3, 1'b0, '0},
         '{3'd1, CMD_HIT,   32'h0000_07CB, 1'b0, '0},
         '{3'd1, CMD_HIT,   32'h0000_0BB3, 1'b0, '0},
         '{3'd1, CMD_HIT,   32'h0000_0000, 1'b0, '0},
         '{3'd2, CMD_START, 32'h8000_0000, 1'b0, '0},
         '{3'd2, CMD_HIT,   32'h0000_0000, 1'b0, '0},
         '{3'd2, CMD_START, 32'h7FFF_FFFF, 1'b0, '0},
         '{3'd2, CMD_HIT,   32'h7FFF_FFFF, 1'b0, '0},
         '{3'd3, CMD_START, 32'h1234_5678, 1'b0, '0},
         '{3'd3, CMD_ECHO,  32'h5555_5555, 1'b0, '0},
         '{3'd4, CMD_START, 32'hAAAA_AAAA, 1'b0, '0},
         '{3'd4, CMD_ARM,   32'h0F0F_0F0F, 1'b0, '0},
         '{3'd4, CMD_HIT,   32'h0000_0001, 1'b0, '0},
         '{3'd4, CMD_HIT,   32'h0000_0002, 1'b0, '0},
         '{3'd4, CMD_HIT,   32'h0000_0003, 1'b0, '0},
         '{3'd4, CMD_HIT,   32'h0000_0004, 1'b0, '0},
         '{3'd4, CMD_HIT,   32'h0000_0005, 1'b0, '0},
         '{3'd4, CMD_HIT,   32'h0000_0006, 1'b0, '0}
      };
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      cur_phase = 3'd0;
      for (i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed_rows[i].phase != cur_phase) begin
            cur_phase = directed_rows[i].phase;
            settle();
            apply_settings(directed_settings(cur_phase));
         end
         item.command = directed_rows[i].command;
         item.encoder_position = directed_rows[i].position;
         send_item(item, directed_rows[i].known, directed_rows[i].result);
      end

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         settle();
         apply_settings(pick_settings());
         overlap_bias = ($urandom_range(0, 1) == 0) ? 15 : 70;
         phase_len = $urandom_range(20, 80);
         repeat (phase_len) begin
            send_item(pick_item(), 1'b0, '0);
            items_sent++;
         end
      end

      settle();
      repeat (100) @(posedge clock);
      if (mismatches == 0 && scan_outcomes.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      int w;
      int taken;
      int quiet;
      taken = 0;
      quiet = 0;
      while (reset) @(posedge clock);
      forever begin
         // one long hold-off so the block backs up into its input
         if (taken == 400) begin
            w = 500;
         end else if (quiet > 0) begin
            w = 0;
            quiet--;
         end else begin
            w = $urandom_range(0, 5);
            if ($urandom_range(0, 40) == 0) quiet = 30;
         end
         repeat (w) begin
            rsp_ready <= 1'b0;
            @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         check_outcome(rsp_data);
         taken++;
      end
   end

   initial begin
      #15_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

@@ filelist.f @@
src/spcs_pkg.sv
src/spcs_mul.sv
src/spcs_div.sv
src/spcs_point.sv
src/scan_position_compare_sequencer.sv
tb/sv/tb.sv
